FILE: rtl/vsa_pkg.sv
`default_nettype none

package vsa_pkg;

  localparam int NUM_PORTS = 5;
  localparam int NUM_VCS   = 4;
  localparam int NUM_ROWS  = NUM_PORTS * NUM_VCS;
  localparam int ROW_W     = $clog2(NUM_ROWS);

  // Field widths are fixed by the interface
  localparam int PORT_W  = 3;
  localparam int CH_W    = 2;
  localparam int PEND_W  = 5;
  localparam int TOTAL_W = $clog2(NUM_ROWS * NUM_ROWS + 1);

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_PICK    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  // One output VC: request row, round-robin pointer, held winner, flags
  typedef struct packed {
    logic [NUM_ROWS-1:0] req;
    logic [ROW_W-1:0]    ptr;
    logic [ROW_W-1:0]    held;
    logic                lock;
    logic                done;
  } entry_t;

  typedef struct packed {
    logic [PORT_W-1:0] winner_port;
    logic [CH_W-1:0]   winner_ch;
    logic              no_winner;
    logic              vc_locked;
    logic [PEND_W-1:0] pending_count;
    logic              all_empty;
  } result_t;

  function automatic logic [PEND_W-1:0] row_popcount(input logic [NUM_ROWS-1:0] bits);
    logic [PEND_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      cnt = cnt + PEND_W'(bits[i]);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vsa_state_ram.sv
`default_nettype none

module vsa_state_ram
  import vsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [ROW_W-1:0] rd_addr_i,
  output entry_t                rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [ROW_W-1:0] wr_addr_i,
  input  wire entry_t           wr_data_i
);

  entry_t              mem [NUM_ROWS];
  entry_t              rd_data_q;
  logic                rd_vld_q;
  logic [NUM_ROWS-1:0] vld_q;

  // entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // per-entry valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/vsa_update.sv
`default_nettype none

module vsa_update
  import vsa_pkg::*;
(
  input  wire cmd_e                cmd_i,
  input  wire logic                out_ok_i,
  input  wire logic                in_ok_i,
  input  wire logic [ROW_W-1:0]    col_i,
  input  wire entry_t              entry_i,
  input  wire logic [TOTAL_W-1:0]  total_i,
  output entry_t                   entry_o,
  output logic                     wr_en_o,
  output logic [TOTAL_W-1:0]       total_o,
  output result_t                  result_o
);

  logic             hi_found, lo_found, found;
  logic [ROW_W-1:0] hi_idx, lo_idx, pick_idx;
  logic             show_held;
  logic [ROW_W-1:0] held;

  // round-robin: first requester above the pointer, else lowest (may be the pointer)
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int i = NUM_ROWS - 1; i >= 0; i--) begin
      if (entry_i.req[i]) begin
        lo_found = 1'b1;
        lo_idx   = ROW_W'(i);
        if (ROW_W'(i) > entry_i.ptr) begin
          hi_found = 1'b1;
          hi_idx   = ROW_W'(i);
        end
      end
    end
    found    = lo_found;
    pick_idx = hi_found ? hi_idx : lo_idx;
  end

  always_comb begin
    entry_o   = entry_i;
    wr_en_o   = 1'b0;
    total_o   = total_i;
    show_held = 1'b1;
    held      = '0;
    result_o  = '0;
    if (!out_ok_i) begin
      result_o.no_winner = (cmd_i == CMD_PICK);
    end else begin
      case (cmd_i)
        CMD_REQUEST: begin
          if (in_ok_i) begin
            wr_en_o      = 1'b1;
            entry_o.done = 1'b0;
            if (!entry_i.req[col_i]) begin
              entry_o.req[col_i] = 1'b1;
              total_o            = total_i + TOTAL_W'(1);
            end
          end
        end
        CMD_CLEAR: begin
          if (in_ok_i) begin
            wr_en_o      = 1'b1;
            entry_o.done = 1'b0;
            entry_o.lock = 1'b0;
            if (entry_i.req[col_i]) begin
              entry_o.req[col_i] = 1'b0;
              total_o            = total_i - TOTAL_W'(1);
            end
          end
        end
        CMD_PICK: begin
          if (entry_i.done || entry_i.lock) begin
            wr_en_o      = 1'b1;
            entry_o.done = 1'b1;
          end else if (found) begin
            wr_en_o      = 1'b1;
            entry_o.ptr  = pick_idx;
            entry_o.held = pick_idx;
            entry_o.done = 1'b1;
            entry_o.lock = 1'b1;
          end else begin
            result_o.no_winner = 1'b1;
            show_held          = 1'b0;
          end
        end
        default: begin
        end
      endcase
      held = entry_o.held;
      if (show_held) begin
        result_o.winner_port = PORT_W'(held / NUM_VCS);
        result_o.winner_ch   = CH_W'(held % NUM_VCS);
      end
      result_o.vc_locked     = entry_o.lock;
      result_o.pending_count = row_popcount(entry_o.req);
    end
    result_o.all_empty = (total_o == '0);
  end

endmodule

`default_nettype wire

FILE: rtl/vc_switch_allocator_round_robin.sv
`default_nettype none

// Channel    Ports                                               Timing
// ---------  --------------------------------------------------  ---------------------------
// command    start, busy, command_i, out_port_i, out_ch_i,       transfer at start && !busy
//            in_port_i, in_ch_i
// result     done_o, winner_port_o, winner_ch_o, no_winner_o,    transfer in the done_o cycle
//            vc_locked_o, pending_count_o, all_empty_o
//
// Each command is read, then computed: the accept edge reads the output VC's entry from the
// state RAM through its registered read port; while busy is high the updated entry is
// written back and the result is registered. busy is high for that compute cycle only,
// and a new command is taken only when busy is low. The result shows on done_o the cycle
// after busy; the receiver cannot stall. After reset all entries read as zero
// through per-entry valid bits; commands are taken from the first cycle.

module vc_switch_allocator_round_robin
  import vsa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        command_i,
  input  wire logic [PORT_W-1:0] out_port_i,
  input  wire logic [CH_W-1:0]   out_ch_i,
  input  wire logic [PORT_W-1:0] in_port_i,
  input  wire logic [CH_W-1:0]   in_ch_i,
  output logic                   done_o,
  output logic [PORT_W-1:0]      winner_port_o,
  output logic [CH_W-1:0]        winner_ch_o,
  output logic                   no_winner_o,
  output logic                   vc_locked_o,
  output logic [PEND_W-1:0]      pending_count_o,
  output logic                   all_empty_o
);

  logic             accept;
  logic             out_ok, in_ok;
  logic [ROW_W-1:0] row, col, rd_addr;

  // command stage (payload, no reset)
  cmd_e             cmd_q;
  logic             out_ok_q, in_ok_q;
  logic [ROW_W-1:0] row_q, col_q;
  logic             busy_q;

  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W-1:0] res_total;
  entry_t             rd_entry, wr_entry;
  logic               wr_en;
  result_t            res_d, res_q;
  logic               done_q;

  assign accept = start && !busy_q;

  assign out_ok = (int'(out_port_i) < NUM_PORTS) && (int'(out_ch_i) < NUM_VCS);
  assign in_ok  = (int'(in_port_i) < NUM_PORTS) && (int'(in_ch_i) < NUM_VCS);
  assign row    = ROW_W'(int'(out_port_i) * NUM_VCS + int'(out_ch_i));
  assign col    = ROW_W'(int'(in_port_i) * NUM_VCS + int'(in_ch_i));
  // out-of-range rows touch nothing; keep the read address in range
  assign rd_addr = out_ok ? row : '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(command_i);
      out_ok_q <= out_ok;
      in_ok_q  <= in_ok;
      row_q    <= rd_addr;
      col_q    <= in_ok ? col : '0;
    end
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      total_q <= '0;
    end else begin
      busy_q  <= accept;
      done_q  <= busy_q;
      total_q <= total_d;
    end
  end

  assign total_d = busy_q ? res_total : total_q;

  vsa_state_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry),
    .wr_en_i   (busy_q && wr_en),
    .wr_addr_i (row_q),
    .wr_data_i (wr_entry)
  );

  vsa_update u_update (
    .cmd_i    (cmd_q),
    .out_ok_i (out_ok_q),
    .in_ok_i  (in_ok_q),
    .col_i    (col_q),
    .entry_i  (rd_entry),
    .total_i  (total_q),
    .entry_o  (wr_entry),
    .wr_en_o  (wr_en),
    .total_o  (res_total),
    .result_o (res_d)
  );

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign winner_port_o   = res_q.winner_port;
  assign winner_ch_o     = res_q.winner_ch;
  assign no_winner_o     = res_q.no_winner;
  assign vc_locked_o     = res_q.vc_locked;
  assign pending_count_o = res_q.pending_count;
  assign all_empty_o     = res_q.all_empty;

  // compute stage lasts exactly one cycle
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("compute stage held longer than one cycle");

  // every accepted command yields a result strobe, through busy_q and then done_q
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_q)
    else $error("result strobe missing after accepted command");

  // a strobe only follows a compute cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("result strobe without compute cycle");

  // empty matrix means the addressed row is empty too
  a_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.all_empty |-> res_q.pending_count == '0)
    else $error("pending requests reported while matrix empty");

  // no_winner comes with a zero winner port and channel
  a_no_winner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.no_winner |-> res_q.winner_port == '0 && res_q.winner_ch == '0)
    else $error("winner reported with no_winner set");

endmodule

`default_nettype wire
